// ===== sv/lmet_pkg.sv =====
// Package: shared constants, types and status codes of the link metric table.
`default_nettype none
package lmet_pkg;
	localparam int NumStations = 32;
	localparam int WarmupSamples = 10;
	localparam int IdxW = (NumStations > 1) ? $clog2(NumStations) : 1;
	localparam int CntW = $clog2(NumStations + 1);

	localparam logic [31:0] CostMax = 32'h7fff_ffff;
	localparam logic [31:0] CostNum = 32'd20971520;
	// ceil(2^31 / 100): exact divide by 100 for any 24-bit value after >> 31
	localparam logic [24:0] RateRecip = 25'd21474837;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_FILTERED = 3'd1,
		ST_FULL     = 3'd2,
		ST_QUERY    = 3'd3,
		ST_UNKNOWN  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_EWMA_SHIFT = 2'd0,
		REG_HYST_SHIFT = 2'd1,
		REG_BASE_RATE  = 2'd2
	} reg_idx_t;

	// Search result handed from the cell row to the controller
	typedef struct packed {
		logic            hit;
		logic [IdxW-1:0] hit_idx;
		logic            free;
		logic [IdxW-1:0] free_idx;
	} search_t;
endpackage
`default_nettype wire

// ===== sv/lmet_if.sv =====
// Interfaces: request, result and configuration channels.
`default_nettype none
interface lmet_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [47:0] mac_addr;
	logic [23:0] throughput;
	modport source (output valid, req_type, mac_addr, throughput, input ready);
	modport sink (input valid, req_type, mac_addr, throughput, output ready);
endinterface

interface lmet_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] metric;
	modport source (output valid, status, metric, input ready);
	modport sink (input valid, status, metric, output ready);
endinterface

interface lmet_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/link_metric_ewma_table_core.sv =====
// Top level: per-station airtime link metric table with EWMA and hysteresis.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type, mac_addr, throughput
//  rsp      out  valid/ready   status, metric
//  cfg      in   valid/ready   index, data
//
// One item at a time. The search walks the row of station cells one slot per
// cycle, the rate in Mbps comes from one reciprocal multiply, 20971520 is
// divided by the rate in a bit-serial divider, and after a setup an update
// takes 1 to 11 EWMA steps, one per cycle, followed by a write-back.
// Reset empties the table.
// A waiting result stalls only the next item's acceptance; the next request
// can transfer in the cycle after the result transfers.
`default_nettype none
module link_metric_ewma_table_core (
	input  wire logic clk,
	input  wire logic arst_n,
	lmet_req_if.sink  req,
	lmet_rsp_if.source rsp,
	lmet_cfg_if.sink  cfg
);
	localparam int N = lmet_pkg::NumStations;
	localparam int IW = lmet_pkg::IdxW;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_RD, S_DIV2, S_DECIDE, S_STEP, S_QUERY, S_OUT
	} state_t;

	state_t            state_q;
	logic              qry_q;
	logic [47:0]       mac_q;
	logic [23:0]       tp_q;
	logic [4:0]        ewma_sh_q;
	logic [4:0]        hyst_sh_q;
	logic [23:0]       base_q;
	logic [lmet_pkg::CntW-1:0] cnt_q;
	logic [5:0]        bit_q;
	logic [31:0]       quo_q;
	logic [31:0]       rem_q;
	logic [31:0]       cost_q;
	logic [31:0]       ewma_q;
	logic [31:0]       rep_q;
	logic [3:0]        samp_q;
	logic [3:0]        steps_q;
	logic [IW-1:0]     ent_q;
	logic [2:0]        status_q;
	logic [31:0]       metric_q;
	logic              rsp_valid_q;

	lmet_pkg::search_t chain [N+1];
	lmet_pkg::search_t res_q;

	// Cell row
	logic        clear;
	logic        alloc;
	assign clear = (state_q == S_IDLE);
	assign chain[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		lmet_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (clear),
			.my_idx (IW'(i)),
			.key    (mac_q),
			.wr_en  (alloc && ent_q == IW'(i)),
			.wr_mac (mac_q),
			.sin    (chain[i]),
			.sout   (chain[i+1])
		);
	end

	// Per-entry data in RAM: ewma, reported, samples
	logic        ram_we;
	logic [67:0] ram_wdata;
	logic [67:0] ram_rdata;
	lmet_ram #(.Width(68), .Depth(N)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ent_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ewma_sh_q <= 5'd3;
			hyst_sh_q <= 5'd3;
			base_q    <= 24'd6000;
		end else if (cfg.valid) begin
			case (cfg.index)
				lmet_pkg::REG_EWMA_SHIFT: ewma_sh_q <= cfg.data[4:0];
				lmet_pkg::REG_HYST_SHIFT: hyst_sh_q <= cfg.data[4:0];
				lmet_pkg::REG_BASE_RATE:  base_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Rate scaling, divider trial subtracts, EWMA step and hysteresis
	logic [23:0] tp_m1;
	logic [48:0] rate_prod;
	logic [32:0] rem_sh;
	logic [31:0] div_den;
	logic [31:0] mbps;
	logic [31:0] step_ewma;
	logic [31:0] band;
	logic [31:0] rep_eff;
	logic [31:0] rep_new;
	logic        move;
	assign tp_m1     = tp_q - 24'd1;
	assign rate_prod = {25'd0, tp_m1} * {24'd0, lmet_pkg::RateRecip};
	assign mbps    = cost_q + 32'd1;
	assign div_den = mbps;
	assign rem_sh  = {rem_q, quo_q[31]};
	assign step_ewma = ewma_q + (cost_q - (ewma_q >> ewma_sh_q));
	assign rep_eff = (rep_q == 32'd0) ? ewma_q : rep_q;
	assign band    = rep_eff >> hyst_sh_q;
	assign move    = (ewma_q > rep_eff + band) || (ewma_q < rep_eff - band);
	assign rep_new = move ? ewma_q : rep_eff;

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign alloc     = (state_q == S_DECIDE) && !qry_q && tp_q != 24'd0 &&
		tp_q != base_q && !res_q.hit && res_q.free;
	assign ram_we    = (state_q == S_STEP && steps_q == 4'd0) ||
		(state_q == S_QUERY);
	assign ram_wdata = {ewma_q, (state_q == S_QUERY) ? rep_new : rep_q, samp_q};

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						qry_q   <= req.req_type;
						mac_q   <= req.mac_addr;
						tp_q    <= req.throughput;
						cnt_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					cnt_q <= cnt_q + lmet_pkg::CntW'(1);
					if (cnt_q == lmet_pkg::CntW'(N)) begin
						res_q   <= chain[N];
						ent_q   <= chain[N].hit ? chain[N].hit_idx : chain[N].free_idx;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// rate minus one from the reciprocal; start the cost divide
					state_q <= S_DIV2;
					rem_q   <= '0;
					bit_q   <= 6'd32;
					cost_q  <= {14'd0, rate_prod[48:31]};
					quo_q   <= lmet_pkg::CostNum;
				end
				S_DIV2: begin
					if (rem_sh >= {1'b0, div_den}) begin
						rem_q <= 32'(rem_sh - {1'b0, div_den});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					logic [31:0] c;
					c = (tp_q == 24'd0) ? lmet_pkg::CostMax :
						((32'd256 + quo_q) >> 8);
					cost_q <= c;
					if (qry_q && res_q.hit) begin
						ewma_q  <= ram_rdata[67:36];
						rep_q   <= ram_rdata[35:4];
						samp_q  <= ram_rdata[3:0];
						state_q <= S_QUERY;
					end else if (qry_q) begin
						status_q <= lmet_pkg::ST_UNKNOWN;
						metric_q <= c;
						state_q  <= S_OUT;
					end else if (tp_q == 24'd0 || tp_q == base_q) begin
						status_q <= lmet_pkg::ST_FILTERED;
						metric_q <= '0;
						state_q  <= S_OUT;
					end else if (!res_q.hit && !res_q.free) begin
						status_q <= lmet_pkg::ST_FULL;
						metric_q <= '0;
						state_q  <= S_OUT;
					end else begin
						status_q <= lmet_pkg::ST_UPDATED;
						metric_q <= '0;
						if (!res_q.hit) begin
							ewma_q <= c << ewma_sh_q;
							rep_q  <= '0;
							samp_q <= '0;
						end else begin
							ewma_q <= ram_rdata[67:36];
							rep_q  <= ram_rdata[35:4];
							samp_q <= ram_rdata[3:0];
						end
						state_q <= S_STEP;
						steps_q <= 4'd0;
						cnt_q   <= '0;
					end
				end
				S_STEP: begin
					// first cycle takes one EWMA step and sets the count of extra warm-up steps
					if (cnt_q == '0) begin
						cnt_q   <= lmet_pkg::CntW'(1);
						ewma_q  <= step_ewma;
						if (samp_q < 4'(lmet_pkg::WarmupSamples)) begin
							steps_q <= 4'(lmet_pkg::WarmupSamples) - samp_q;
							samp_q  <= samp_q + 4'd1;
						end else begin
							steps_q <= 4'd0;
						end
					end else if (steps_q != 4'd0) begin
						ewma_q  <= step_ewma;
						steps_q <= steps_q - 4'd1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_QUERY: begin
					rep_q    <= rep_new;
					metric_q <= rep_new >> ewma_sh_q;
					status_q <= lmet_pkg::ST_QUERY;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.metric = metric_q;

	// A pending result is seen only in the idle or search state
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (state_q == S_IDLE || state_q == S_SEARCH))
		else $error("result pending while busy");
	// Allocation only into a free slot
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |-> res_q.free)
		else $error("allocation without free slot");
	// Result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(metric_q))
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== sv/lmet_cell.sv =====
// Cell: one station slot that checks the shared key against its entry and passes the search on.
`default_nettype none
module lmet_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clear,
	input  wire logic [lmet_pkg::IdxW-1:0] my_idx,
	input  wire logic [47:0]               key,
	input  wire logic                      wr_en,
	input  wire logic [47:0]               wr_mac,
	input  wire lmet_pkg::search_t         sin,
	output lmet_pkg::search_t              sout
);
	logic              valid_q;
	logic [47:0]       mac_q;
	lmet_pkg::search_t sout_d;

	// Hold the key and the valid flag of this slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mac_q <= wr_mac;
		end
	end

	// Merge this slot into the search; earliest match/free wins
	always_comb begin
		sout_d = sin;
		if (!sin.hit && valid_q && mac_q == key) begin
			sout_d.hit     = 1'b1;
			sout_d.hit_idx = my_idx;
		end
		if (!sin.free && !valid_q) begin
			sout_d.free     = 1'b1;
			sout_d.free_idx = my_idx;
		end
	end

	// Advance the search result one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sout <= '0;
		end else if (clear) begin
			sout <= '0;
		end else begin
			sout <= sout_d;
		end
	end
endmodule
`default_nettype wire

// ===== sv/lmet_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module lmet_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== verif/tb_link_metric_ewma_table_core.sv =====
// Testbench: random and directed traffic into the link metric table, checked against a predictor.
`timescale 1ns / 100ps
module tb_link_metric_ewma_table_core;

	localparam int CycleLimit = 1_000_000;
	localparam int DrainCycles = 160;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] metric;
	} lm_result_t;

	// Predicts the station table and holds the results still owed by the block
	class ewma_table_scoreboard;
		bit          sta_valid[lmet_pkg::NumStations];
		logic [47:0] sta_mac[lmet_pkg::NumStations];
		logic [31:0] sta_ewma[lmet_pkg::NumStations];
		logic [3:0]  sta_samples[lmet_pkg::NumStations];
		logic [31:0] sta_reported[lmet_pkg::NumStations];
		logic [4:0]  ewma_sh;
		logic [4:0]  hyst_sh;
		logic [23:0] base_rate;
		lm_result_t  owed_q[$];
		int          mismatches;

		function new();
			foreach (sta_valid[i]) sta_valid[i] = 1'b0;
			ewma_sh = 5'd3;
			hyst_sh = 5'd3;
			base_rate = 24'd6000;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] data);
			case (idx)
				lmet_pkg::REG_EWMA_SHIFT: ewma_sh = data[4:0];
				lmet_pkg::REG_HYST_SHIFT: hyst_sh = data[4:0];
				lmet_pkg::REG_BASE_RATE:  base_rate = data;
				default: ;
			endcase
		endfunction

		function logic [31:0] airtime(logic [23:0] tp);
			logic [31:0] mbps;
			if (tp == 24'd0) return lmet_pkg::CostMax;
			mbps = 32'd1 + (32'(tp) - 32'd1) / 32'd100;
			return (32'd256 + lmet_pkg::CostNum / mbps) >> 8;
		endfunction

		function void fold(int e, logic [31:0] cost);
			sta_ewma[e] = sta_ewma[e] + (cost - (sta_ewma[e] >> ewma_sh));
		endfunction

		// Work out the result of one accepted request and update the table
		function void note_request(logic qry, logic [47:0] m, logic [23:0] tp);
			logic [31:0] cost;
			logic [31:0] band;
			lm_result_t  r;
			int          e;
			cost = airtime(tp);
			r.metric = '0;
			e = -1;
			for (int i = 0; i < lmet_pkg::NumStations; i++)
				if (e < 0 && sta_valid[i] && sta_mac[i] == m) e = i;
			if (qry) begin
				if (e < 0) begin
					r.status = lmet_pkg::ST_UNKNOWN;
					r.metric = cost;
				end else begin
					if (sta_reported[e] == 32'd0) sta_reported[e] = sta_ewma[e];
					band = sta_reported[e] >> hyst_sh;
					if (sta_ewma[e] > sta_reported[e] + band ||
					    sta_ewma[e] < sta_reported[e] - band)
						sta_reported[e] = sta_ewma[e];
					r.status = lmet_pkg::ST_QUERY;
					r.metric = sta_reported[e] >> ewma_sh;
				end
			end else if (tp == 24'd0 || tp == base_rate) begin
				r.status = lmet_pkg::ST_FILTERED;
			end else begin
				if (e < 0) begin
					for (int i = 0; i < lmet_pkg::NumStations; i++)
						if (e < 0 && !sta_valid[i]) e = i;
					if (e >= 0) begin
						sta_valid[e] = 1'b1;
						sta_mac[e] = m;
						sta_ewma[e] = cost << ewma_sh;
						sta_samples[e] = 4'd0;
						sta_reported[e] = 32'd0;
					end
				end
				if (e < 0) begin
					r.status = lmet_pkg::ST_FULL;
				end else begin
					fold(e, cost);
					if (sta_samples[e] < lmet_pkg::WarmupSamples) begin
						for (int k = lmet_pkg::WarmupSamples; k > sta_samples[e]; k--)
							fold(e, cost);
						sta_samples[e] = sta_samples[e] + 4'd1;
					end
					r.status = lmet_pkg::ST_UPDATED;
				end
			end
			owed_q.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [31:0] metric);
			lm_result_t exp_r;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d metric %h", st, metric);
				return;
			end
			exp_r = owed_q.pop_front();
			if (exp_r.status !== st || exp_r.metric !== metric) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected status %0d metric %h, got status %0d metric %h",
						exp_r.status, exp_r.metric, st, metric);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   burst_left;
	int   stall_left;
	int   stall_pct;
	logic [47:0] mac_pool[24];
	ewma_table_scoreboard sb;

	lmet_req_if req_ch ();
	lmet_rsp_if rsp_ch ();
	lmet_cfg_if cfg_ch ();

	link_metric_ewma_table_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Watch every transfer and bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.req_type, req_ch.mac_addr, req_ch.throughput);
			if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.status, rsp_ch.metric);
		end
	end

	// Stall the result channel in random stretches
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < stall_pct) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(40);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_req(input logic qry, input logic [47:0] m, input logic [23:0] tp);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= qry;
		req_ch.mac_addr <= m;
		req_ch.throughput <= tp;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = $urandom_range(12);
		end
	endtask

	task automatic write_cfg(input lmet_pkg::reg_idx_t idx, input logic [23:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop the request, hold until every owed result has come, then let the core settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic send_random();
		logic        qry;
		logic [47:0] m;
		logic [23:0] tp;
		int          pick;
		qry = ($urandom_range(99) < 30);
		m = ($urandom_range(99) < 10) ? {16'($urandom), 32'($urandom)}
			: mac_pool[$urandom_range(23)];
		pick = $urandom_range(99);
		if (pick < 5) tp = 24'd0;
		else if (pick < 10) tp = sb.base_rate;
		else if (pick < 40) tp = 24'($urandom_range(1, 300));
		else if (pick < 70) tp = 24'($urandom_range(1, 20000));
		else tp = 24'($urandom);
		send_req(qry, m, tp);
	endtask

	initial begin
		logic [47:0] sta_a;
		cycles = 0;
		burst_left = 0;
		stall_left = 0;
		stall_pct = 0;
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.mac_addr = '0;
		req_ch.throughput = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), 32'($urandom)};
		mac_pool[0] = 48'h0;
		mac_pool[1] = 48'hffff_ffff_ffff;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: rate extremes, filtering, new and unknown stations
		sta_a = mac_pool[2];
		send_req(1'b1, sta_a, 24'd0);
		send_req(1'b1, sta_a, 24'd1);
		send_req(1'b1, sta_a, 24'hffffff);
		send_req(1'b0, sta_a, 24'd1);
		send_req(1'b1, sta_a, 24'd0);
		send_req(1'b0, sta_a, 24'd100);
		send_req(1'b0, sta_a, 24'd101);
		send_req(1'b0, sta_a, 24'hffffff);
		send_req(1'b0, sta_a, 24'd0);
		send_req(1'b0, sta_a, 24'd6000);
		send_req(1'b1, sta_a, 24'd5);
		send_req(1'b0, 48'h0, 24'd1);
		send_req(1'b0, 48'hffff_ffff_ffff, 24'hffffff);
		send_req(1'b1, 48'hffff_ffff_ffff, 24'd0);
		send_req(1'b1, 48'h0, 24'd0);
		repeat (8) send_req(1'b0, sta_a, 24'($urandom_range(1, 30000)));
		send_req(1'b1, sta_a, 24'd0);
		send_req(1'b1, sta_a, 24'd0);

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				1: begin
					write_cfg(lmet_pkg::REG_EWMA_SHIFT, 24'd0);
					write_cfg(lmet_pkg::REG_HYST_SHIFT, 24'd0);
					write_cfg(lmet_pkg::REG_BASE_RATE, 24'd0);
				end
				2: begin
					write_cfg(lmet_pkg::REG_EWMA_SHIFT, 24'd16);
					write_cfg(lmet_pkg::REG_HYST_SHIFT, 24'd31);
					write_cfg(lmet_pkg::REG_BASE_RATE, 24'hffffff);
				end
				3: begin
					write_cfg(lmet_pkg::REG_EWMA_SHIFT, 24'd1);
					write_cfg(lmet_pkg::REG_HYST_SHIFT, 24'd1);
					write_cfg(lmet_pkg::REG_BASE_RATE, 24'd100);
				end
				4: begin
					write_cfg(lmet_pkg::REG_EWMA_SHIFT, 24'd31);
					write_cfg(lmet_pkg::REG_HYST_SHIFT, 24'd0);
					write_cfg(lmet_pkg::REG_BASE_RATE, 24'd50);
				end
				5: begin
					write_cfg(lmet_pkg::REG_EWMA_SHIFT, 24'd5);
					write_cfg(lmet_pkg::REG_HYST_SHIFT, 24'd4);
					write_cfg(lmet_pkg::REG_BASE_RATE, 24'd1);
				end
				default: ;
			endcase
			stall_pct = (ph == 0) ? 0 : ph * 8;
			for (int n = 0; n < 250; n++) begin
				if (n == 125) drain();
				send_random();
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/lmet_pkg.sv
sv/lmet_if.sv
sv/lmet_cell.sv
sv/lmet_ram.sv
sv/link_metric_ewma_table_core.sv
verif/tb_link_metric_ewma_table_core.sv
